// ===== rtl/pbrb_pkg.sv =====
package pbrb_pkg;

    localparam int BLOCKS_DEF          = 8;
    localparam int SLOTS_PER_BLOCK_DEF = 32;
    localparam int PACKET_BITS_DEF     = 64;

    localparam int OPCODE_W  = 2;
    localparam int WORD_W    = 64;
    localparam int SLOT_IN_W = 5;
    localparam int STORED_W  = 4;
    localparam int DROP_W    = 32;

    localparam logic [DROP_W-1:0] DROP_MAX = 32'hffff_ffff;

    localparam int STORE_DEPTH_DEF = BLOCKS_DEF * SLOTS_PER_BLOCK_DEF;
    localparam int STORE_AW_DEF    = $clog2(STORE_DEPTH_DEF);

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_READ = 2'd2
    } t_opcode;

endpackage

// ===== rtl/pbrb_store.sv =====
module pbrb_store #(
    parameter int DEPTH = pbrb_pkg::STORE_DEPTH_DEF,
    parameter int AW    = pbrb_pkg::STORE_AW_DEF,
    parameter int DW    = pbrb_pkg::PACKET_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/packet_block_ring_buffer_top.sv =====
// The result strobe o_valid rises the cycle after start is taken.
// Throughput: one operation per cycle; busy is never asserted.
// Push and pop update the ring state; an accepted push writes the packet store and a read reads it.
// The receiver cannot stall; every result appears for exactly one cycle.
// Reset (synchronous, active low) empties the ring and clears the drop counter;
// no clearing pass over the packet store is needed.
module packet_block_ring_buffer_top #(
    parameter int BLOCKS          = pbrb_pkg::BLOCKS_DEF,
    parameter int SLOTS_PER_BLOCK = pbrb_pkg::SLOTS_PER_BLOCK_DEF,
    parameter int PACKET_BITS     = pbrb_pkg::PACKET_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pbrb_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [pbrb_pkg::WORD_W-1:0]    i_packet_word,
    input  logic [pbrb_pkg::SLOT_IN_W-1:0] i_slot_index,
    output logic                           o_valid,
    output logic                           o_accepted,
    output logic                           o_block_closed,
    output logic                           o_block_ready,
    output logic [pbrb_pkg::WORD_W-1:0]    o_read_data,
    output logic [pbrb_pkg::STORED_W-1:0]  o_blocks_stored,
    output logic [pbrb_pkg::DROP_W-1:0]    o_dropped_count
);

    localparam int DEPTH = BLOCKS * SLOTS_PER_BLOCK;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(BLOCKS);
    localparam int FW    = $clog2(SLOTS_PER_BLOCK + 1);
    localparam int CW    = $clog2(BLOCKS + 1);
    localparam int WW    = pbrb_pkg::WORD_W;
    localparam int SW    = pbrb_pkg::STORED_W;
    localparam int DRW   = pbrb_pkg::DROP_W;

    logic [BW-1:0]  r_head, n_head;
    logic [BW-1:0]  r_tail, n_tail;
    logic [CW-1:0]  r_complete, n_complete;
    logic [FW-1:0]  r_fill, n_fill;
    logic           r_open, n_open;
    logic [DRW-1:0] r_drop, n_drop;
    logic           r_valid;
    logic           r_accepted, n_accepted;
    logic           r_closed, n_closed;
    logic           r_hit, n_hit;

    logic                   w_accept;
    logic                   w_we;
    logic                   w_re;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr;
    logic [FW-1:0]          w_slot_pos;
    logic [FW-1:0]          w_fill_next;
    logic [PACKET_BITS-1:0] w_rdata;
    logic [PACKET_BITS+WW-1:0] w_rdata_ext;
    logic [CW+SW-1:0]       w_stored_ext;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_slot_pos  = r_open ? r_fill : '0;
    assign w_fill_next = FW'(w_slot_pos + 1'b1);
    assign w_waddr     = AW'(AW'(r_head) * AW'(SLOTS_PER_BLOCK) + AW'(w_slot_pos));
    assign w_raddr     = AW'(AW'(r_tail) * AW'(SLOTS_PER_BLOCK) + AW'(i_slot_index));

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_complete = r_complete;
        n_fill     = r_fill;
        n_open     = r_open;
        n_drop     = r_drop;
        n_accepted = 1'b0;
        n_closed   = 1'b0;
        n_hit      = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        if (w_accept) begin
            unique case (pbrb_pkg::t_opcode'(i_opcode))
                pbrb_pkg::OP_PUSH: begin
                    if (r_open || (32'(r_complete) < BLOCKS)) begin
                        w_we       = 1'b1;
                        n_accepted = 1'b1;
                        if (32'(w_fill_next) == SLOTS_PER_BLOCK) begin
                            n_head     = (r_head == BW'(BLOCKS - 1)) ? '0 : BW'(r_head + 1'b1);
                            n_complete = CW'(r_complete + 1'b1);
                            n_open     = 1'b0;
                            n_fill     = '0;
                            n_closed   = 1'b1;
                        end else begin
                            n_open = 1'b1;
                            n_fill = w_fill_next;
                        end
                    end else if (r_drop != pbrb_pkg::DROP_MAX) begin
                        n_drop = DRW'(r_drop + 1'b1);
                    end
                end
                pbrb_pkg::OP_POP: begin
                    if (r_complete != '0) begin
                        n_tail     = (r_tail == BW'(BLOCKS - 1)) ? '0 : BW'(r_tail + 1'b1);
                        n_complete = CW'(r_complete - 1'b1);
                    end
                end
                pbrb_pkg::OP_READ: begin
                    w_re = 1'b1;
                    // tail block is full when any block is complete, else it is the open one
                    if (32'(i_slot_index) < SLOTS_PER_BLOCK) begin
                        n_hit = (r_complete != '0) ||
                                (r_open && (32'(i_slot_index) < 32'(r_fill)));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_complete <= '0;
            r_fill     <= '0;
            r_open     <= 1'b0;
            r_drop     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_complete <= n_complete;
            r_fill     <= n_fill;
            r_open     <= n_open;
            r_drop     <= n_drop;
            r_valid    <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_accepted <= n_accepted;
        r_closed   <= n_closed;
        r_hit      <= n_hit;
    end

    pbrb_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PACKET_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_packet_word[PACKET_BITS-1:0]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rdata_ext  = {{WW{1'b0}}, (r_hit ? w_rdata : '0)};
    assign w_stored_ext = {{SW{1'b0}}, r_complete};

    assign o_valid         = r_valid;
    assign o_accepted      = r_accepted;
    assign o_block_closed  = r_closed;
    assign o_block_ready   = (r_complete != '0);
    assign o_read_data     = w_rdata_ext[WW-1:0];
    assign o_blocks_stored = w_stored_ext[SW-1:0];
    assign o_dropped_count = r_drop;

    a_complete_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_complete) <= BLOCKS)
        else $error("complete block count exceeds ring size");

    a_open_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (32'(r_complete) < BLOCKS))
        else $error("open block while ring is full");

    a_empty_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_complete == '0) || (32'(r_complete) == BLOCKS)) |-> (r_head == r_tail))
        else $error("head and tail disagree with complete count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) < SLOTS_PER_BLOCK)
        else $error("fill position out of range");

    a_result_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start))
        else $error("result without a start transfer");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

    localparam int OPCODE_W    = pbrb_pkg::OPCODE_W;
    localparam int WORD_W      = pbrb_pkg::WORD_W;
    localparam int SLOT_IN_W   = pbrb_pkg::SLOT_IN_W;
    localparam int STORED_W    = pbrb_pkg::STORED_W;
    localparam int DROP_W      = pbrb_pkg::DROP_W;

    localparam int BLOCKS      = pbrb_pkg::BLOCKS_DEF;
    localparam int SLOTS       = pbrb_pkg::SLOTS_PER_BLOCK_DEF;
    localparam int PACKET_BITS = pbrb_pkg::PACKET_BITS_DEF;
    localparam int STORE_DEPTH = BLOCKS * SLOTS;

    localparam logic [WORD_W-1:0] WORD_MASK = (PACKET_BITS >= 64) ? {WORD_W{1'b1}}
                                            : ((64'd1 << PACKET_BITS) - 64'd1);
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int DIR_ROWS       = 18;
    localparam int RAND_ITEMS     = 1032;
    localparam int FILL_END_A     = 350;
    localparam int DRAIN_END_A    = 500;
    localparam int FILL_END_B     = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                accepted;
        logic                closed;
        logic                ready;
        logic [WORD_W-1:0]   rdata;
        logic [STORED_W-1:0] stored;
        logic [DROP_W-1:0]   dropped;
    } t_ring_status;

    typedef struct packed {
        logic [OPCODE_W-1:0]  op;
        logic [WORD_W-1:0]    word;
        logic [SLOT_IN_W-1:0] slot;
        logic                 chk;
        t_ring_status         res;
    } t_stim_row;

    localparam t_ring_status NO_STATUS = '0;
    localparam t_ring_status PUSH_OK   = '{1'b1, 1'b0, 1'b0, 64'h0, 4'h0, 32'h0};
    localparam t_ring_status READ_ONES = '{1'b0, 1'b0, 1'b0, {WORD_W{1'b1}}, 4'h0, 32'h0};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [OPCODE_W-1:0]  i_opcode;
    logic [WORD_W-1:0]    i_packet_word;
    logic [SLOT_IN_W-1:0] i_slot_index;
    logic                 o_valid;
    logic                 o_accepted;
    logic                 o_block_closed;
    logic                 o_block_ready;
    logic [WORD_W-1:0]    o_read_data;
    logic [STORED_W-1:0]  o_blocks_stored;
    logic [DROP_W-1:0]    o_dropped_count;

    // table expectation travels with the transfer it belongs to
    logic                 row_chk;
    t_ring_status         row_res;

    packet_block_ring_buffer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_packet_word   (i_packet_word),
        .i_slot_index    (i_slot_index),
        .o_valid         (o_valid),
        .o_accepted      (o_accepted),
        .o_block_closed  (o_block_closed),
        .o_block_ready   (o_block_ready),
        .o_read_data     (o_read_data),
        .o_blocks_stored (o_blocks_stored),
        .o_dropped_count (o_dropped_count)
    );

    logic [WORD_W-1:0] pkt_mem [STORE_DEPTH];
    bit                slot_written [STORE_DEPTH];
    int unsigned       head_blk;
    int unsigned       tail_blk;
    int unsigned       blocks_done;
    int unsigned       fill_pos;
    bit                blk_open;
    logic [DROP_W-1:0] drop_cnt;

    t_ring_status status_q [$];
    t_ring_status want_st;
    t_ring_status got_st;
    t_ring_status pred_st;
    int           err_cnt;
    int           stall_cnt;
    int           idle_pct;
    t_stim_row    dir_tab [DIR_ROWS];

    task automatic ring_step(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] word,
                             input logic [SLOT_IN_W-1:0] slot, output t_ring_status r);
        bit          ok;
        int unsigned idx;
        int unsigned base;
        r = '0;
        if (op == pbrb_pkg::OP_PUSH) begin
            ok = blk_open;
            if (!ok) begin
                if (blocks_done < BLOCKS) begin
                    blk_open = 1'b1;
                    fill_pos = 0;
                    ok = 1'b1;
                end else if (drop_cnt != pbrb_pkg::DROP_MAX) begin
                    drop_cnt = drop_cnt + 1'b1;
                end
            end
            if (ok) begin
                idx = head_blk * SLOTS + fill_pos;
                pkt_mem[idx] = word & WORD_MASK;
                slot_written[idx] = 1'b1;
                fill_pos++;
                r.accepted = 1'b1;
                if (fill_pos >= SLOTS) begin
                    head_blk = (head_blk + 1 >= BLOCKS) ? 0 : head_blk + 1;
                    blocks_done++;
                    blk_open = 1'b0;
                    fill_pos = 0;
                    r.closed = 1'b1;
                end
            end
        end else if (op == pbrb_pkg::OP_POP) begin
            if (blocks_done > 0) begin
                base = tail_blk * SLOTS;
                for (int i = 0; i < SLOTS; i++) begin
                    pkt_mem[base + i] = '0;
                    slot_written[base + i] = 1'b0;
                end
                tail_blk = (tail_blk + 1 >= BLOCKS) ? 0 : tail_blk + 1;
                blocks_done--;
            end
        end else if (op == pbrb_pkg::OP_READ) begin
            if (slot < SLOTS) begin
                idx = tail_blk * SLOTS + slot;
                if (slot_written[idx]) r.rdata = pkt_mem[idx];
            end
        end
        r.ready   = (blocks_done > 0);
        r.stored  = blocks_done[STORED_W-1:0];
        r.dropped = drop_cnt;
    endtask

    task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] word,
                           input logic [SLOT_IN_W-1:0] slot, input logic chk,
                           input t_ring_status res);
        while ($urandom_range(99) < idle_pct) begin
            start         <= 1'b0;
            i_opcode      <= OPCODE_W'($urandom);
            i_packet_word <= {$urandom, $urandom};
            i_slot_index  <= SLOT_IN_W'($urandom);
            row_chk       <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_packet_word <= word;
        i_slot_index  <= slot;
        row_chk       <= chk;
        row_res       <= res;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        head_blk    = 0;
        tail_blk    = 0;
        blocks_done = 0;
        fill_pos    = 0;
        blk_open    = 1'b0;
        drop_cnt    = '0;
        err_cnt     = 0;
        stall_cnt   = 0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            pkt_mem[i] = '0;
            slot_written[i] = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                got_st = {o_accepted, o_block_closed, o_block_ready, o_read_data,
                          o_blocks_stored, o_dropped_count};
                if (status_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected result: acc=%b cls=%b rdy=%b rd=%h st=%0d drop=%0d",
                                 got_st.accepted, got_st.closed, got_st.ready, got_st.rdata,
                                 got_st.stored, got_st.dropped);
                end else begin
                    want_st = status_q.pop_front();
                    if (got_st !== want_st) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("mismatch exp: acc=%b cls=%b rdy=%b rd=%h st=%0d drop=%0d",
                                     want_st.accepted, want_st.closed, want_st.ready,
                                     want_st.rdata, want_st.stored, want_st.dropped);
                            $display("         got: acc=%b cls=%b rdy=%b rd=%h st=%0d drop=%0d",
                                     got_st.accepted, got_st.closed, got_st.ready,
                                     got_st.rdata, got_st.stored, got_st.dropped);
                        end
                    end
                end
            end
            if (start && !busy) begin
                ring_step(i_opcode, i_packet_word, i_slot_index, pred_st);
                status_q.push_back(row_chk ? row_res : pred_st);
            end
            if (!(start && !busy) && !o_valid) stall_cnt++;
            else stall_cnt = 0;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int                   pick;
        logic [OPCODE_W-1:0]  op;
        bit                   filling;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_opcode      <= '0;
        i_packet_word <= '0;
        i_slot_index  <= '0;
        row_chk       <= 1'b0;
        row_res       <= '0;
        idle_pct      = 21;

        dir_tab[0]  = '{pbrb_pkg::OP_READ, 64'h0,                  5'd0,  1'b1, NO_STATUS};
        dir_tab[1]  = '{pbrb_pkg::OP_POP,  64'h0,                  5'd0,  1'b1, NO_STATUS};
        dir_tab[2]  = '{OP_UNUSED,         64'hffff_ffff_ffff_ffff, 5'd31, 1'b1, NO_STATUS};
        dir_tab[3]  = '{pbrb_pkg::OP_READ, 64'h0,                  5'd31, 1'b1, NO_STATUS};
        dir_tab[4]  = '{pbrb_pkg::OP_PUSH, 64'hffff_ffff_ffff_ffff, 5'd0,  1'b1, PUSH_OK};
        dir_tab[5]  = '{pbrb_pkg::OP_PUSH, 64'h0,                  5'd31, 1'b1, PUSH_OK};
        dir_tab[6]  = '{pbrb_pkg::OP_PUSH, 64'h8000_0000_0000_0001, 5'd0,  1'b0, NO_STATUS};
        dir_tab[7]  = '{pbrb_pkg::OP_PUSH, 64'h5555_5555_5555_5555, 5'd21, 1'b0, NO_STATUS};
        dir_tab[8]  = '{pbrb_pkg::OP_READ, 64'h0,                  5'd0,  1'b1, READ_ONES};
        dir_tab[9]  = '{pbrb_pkg::OP_READ, 64'hffff_ffff_ffff_ffff, 5'd1,  1'b0, NO_STATUS};
        dir_tab[10] = '{pbrb_pkg::OP_READ, 64'h0,                  5'd2,  1'b0, NO_STATUS};
        dir_tab[11] = '{pbrb_pkg::OP_READ, 64'h0,                  5'd3,  1'b0, NO_STATUS};
        dir_tab[12] = '{pbrb_pkg::OP_READ, 64'h0,                  5'd4,  1'b1, NO_STATUS};
        dir_tab[13] = '{pbrb_pkg::OP_READ, 64'h0,                  5'd31, 1'b1, NO_STATUS};
        dir_tab[14] = '{pbrb_pkg::OP_POP,  64'hffff_ffff_ffff_ffff, 5'd31, 1'b1, NO_STATUS};
        dir_tab[15] = '{OP_UNUSED,         64'h0,                  5'd0,  1'b0, NO_STATUS};
        dir_tab[16] = '{pbrb_pkg::OP_PUSH, 64'haaaa_aaaa_aaaa_aaaa, 5'd10, 1'b0, NO_STATUS};
        dir_tab[17] = '{pbrb_pkg::OP_READ, 64'h0,                  5'd4,  1'b0, NO_STATUS};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_op(dir_tab[r].op, dir_tab[r].word, dir_tab[r].slot, dir_tab[r].chk,
                    dir_tab[r].res);

        // alternate fill-heavy and drain-heavy stretches so the ring fills and drops
        for (int n = 0; n < RAND_ITEMS; n++) begin
            idle_pct = (n < RAND_ITEMS / 3) ? 21 : (n < 2 * RAND_ITEMS / 3) ? 46 : 0;
            filling  = (n < FILL_END_A) || (n >= DRAIN_END_A && n < FILL_END_B);
            pick     = $urandom_range(99);
            if (filling)
                op = (pick < 88) ? pbrb_pkg::OP_PUSH
                   : (pick < 98) ? pbrb_pkg::OP_READ : OP_UNUSED;
            else
                op = (pick < 25) ? pbrb_pkg::OP_POP : (pick < 75) ? pbrb_pkg::OP_READ
                   : (pick < 98) ? pbrb_pkg::OP_PUSH : OP_UNUSED;
            send_op(op, {$urandom, $urandom}, SLOT_IN_W'($urandom_range(31)), 1'b0,
                    NO_STATUS);
        end

        start   <= 1'b0;
        row_chk <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== packet_block_ring_buffer_top.f =====
rtl/pbrb_pkg.sv
rtl/pbrb_store.sv
rtl/packet_block_ring_buffer_top.sv
bench/tb_top.sv
